### hdl/bfbb_pkg.sv
package bfbb_pkg;

    // Ring geometry
    localparam int DEPTH = 256;
    localparam int PTR_W = $clog2(DEPTH);

    // Field widths
    localparam int HANDLE_W  = 32;
    localparam int LENGTH_W  = 16;
    localparam int COUNT_W   = 9;
    localparam int BYTES_W   = 25;
    localparam int CLIMIT_W  = 9;
    localparam int BLIMIT_W  = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 24;

    // Ring capacity in count units
    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

    // Limit values after reset
    localparam logic [CLIMIT_W-1:0] COUNT_LIMIT_RST = 9'd256;
    localparam logic [BLIMIT_W-1:0] BYTE_LIMIT_RST  = 24'h100000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT  = 1'd1;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_LEN = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        t_op                 operation;
        logic [HANDLE_W-1:0] entry_handle;
        logic [LENGTH_W-1:0] entry_length;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] popped_handle;
        logic [LENGTH_W-1:0] popped_length;
        logic [COUNT_W-1:0]  entries_held;
        logic [BYTES_W-1:0]  bytes_held;
    } t_out_item;

    // One stored queue entry
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } t_entry;

    // Ring store access for one cycle
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        t_entry           wdata;
        logic [PTR_W-1:0] raddr;
    } t_ring_req;

    // Advance a ring position with wrap
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
        return (pos == PTR_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

endpackage

### hdl/bfbb_ring.sv
module bfbb_ring import bfbb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_req i_req,
    output t_entry    o_front
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;
    t_entry r_byp_data;
    logic   r_byp;

    // Write at the tail, read the next head position
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    // Forward data written to the position being read this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= i_req.we && (i_req.waddr == i_req.raddr);
        end
        r_byp_data <= i_req.wdata;
    end

    assign o_front = r_byp ? r_byp_data : r_rd_data;

endmodule

### hdl/bfbb_adm.sv
module bfbb_adm import bfbb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  t_in_item             i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  t_entry               i_front,
    output t_ring_req            o_ring_req,
    output t_out_item            o_result
);

    logic [CLIMIT_W-1:0] r_count_limit;
    logic [BLIMIT_W-1:0] r_byte_limit;
    logic [PTR_W-1:0]    r_head;
    logic [PTR_W-1:0]    r_tail;
    logic [COUNT_W-1:0]  r_count;
    logic [BYTES_W-1:0]  r_bytes;

    logic [PTR_W-1:0]    n_head;
    logic [PTR_W-1:0]    n_tail;
    logic [COUNT_W-1:0]  n_count;
    logic [BYTES_W-1:0]  n_bytes;

    logic                is_pop;
    logic                full;
    logic                push_ok;
    logic                pop_ok;
    t_status             status;

    // Admission checks against the state before this transaction
    always_comb begin
        is_pop  = (i_item.operation == OP_POP);
        full    = (r_count >= r_count_limit)
               || (r_bytes >= {1'b0, r_byte_limit})
               || (r_count >= DEPTH_CNT);
        push_ok = !is_pop && (i_item.entry_length != '0) && !full;
        pop_ok  = is_pop && (r_count != '0);

        if (is_pop) begin
            status = pop_ok ? ST_OK : ST_EMPTY;
        end else if (i_item.entry_length == '0) begin
            status = ST_ZERO_LEN;
        end else if (full) begin
            status = ST_FULL;
        end else begin
            status = ST_OK;
        end
    end

    // Next occupancy and ring positions
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_bytes = r_bytes;
        if (push_ok) begin
            n_tail  = ring_next(r_tail);
            n_count = r_count + 1'b1;
            n_bytes = r_bytes + BYTES_W'(i_item.entry_length);
        end else if (pop_ok) begin
            n_head  = ring_next(r_head);
            n_count = r_count - 1'b1;
            n_bytes = r_bytes - BYTES_W'(i_front.length);
        end
    end

    // Ring access: write on accepted push, read ahead of the head
    always_comb begin
        o_ring_req.we           = i_go && push_ok;
        o_ring_req.waddr        = r_tail;
        o_ring_req.wdata.handle = i_item.entry_handle;
        o_ring_req.wdata.length = i_item.entry_length;
        o_ring_req.raddr        = i_go ? n_head : r_head;
    end

    // Result of this transaction
    always_comb begin
        o_result.status        = status;
        o_result.popped_handle = pop_ok ? i_front.handle : '0;
        o_result.popped_length = pop_ok ? i_front.length : '0;
        o_result.entries_held  = n_count;
        o_result.bytes_held    = n_bytes;
    end

    // Hold queue state and limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limit <= COUNT_LIMIT_RST;
            r_byte_limit  <= BYTE_LIMIT_RST;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_bytes       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COUNT_LIMIT: r_count_limit <= i_cfg_data[CLIMIT_W-1:0];
                    CFG_BYTE_LIMIT:  r_byte_limit  <= i_cfg_data[BLIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_go) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_bytes <= n_bytes;
            end
        end
    end

    a_count_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("entry count beyond ring capacity");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_bytes == '0))
        else $error("byte total left over on empty queue");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && push_ok) |=> (r_count == $past(r_count) + 1'b1)
                           && (r_tail == ring_next($past(r_tail))))
        else $error("accepted push did not advance count and tail");

endmodule

### hdl/bfbb_oreg.sv
module bfbb_oreg import bfbb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_item o_item,
    output logic      o_busy
);

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      take;

    assign take = r_out_valid && !i_stall;

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_load;
            end
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves
    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end
        if (i_load && r_out_valid && !take) begin
            r_skid <= i_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign o_busy  = r_skid_valid;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

endmodule

### hdl/bounded_fifo_with_byte_budget_top.sv
// Channel   Valid        Stall        Payload      Direction
// input     i_in_valid   o_in_stall   i_in_item    push or pop request
// output    o_out_valid  i_out_stall  o_out_item   status, popped entry, occupancy
// config    i_cfg_we     -            i_cfg_data   limit write at i_cfg_index
//
// One transaction per cycle while o_in_stall is low: checks and occupancy update
// are done in the accept cycle from the state registers and the prefetched head
// entry of the ring. The result is registered into the output or skid entry.
// Reset clears count, byte total and ring positions at once; the ring store
// itself is not cleared, so no clearing pass is needed.
// A result stalled at the output moves to a skid entry; o_in_stall is high
// only while that skid entry is occupied.
module bounded_fifo_with_byte_budget_top import bfbb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic      go;
    logic      busy;
    t_ring_req ring_req;
    t_entry    front;
    t_out_item result;

    // Accept while the skid entry is free
    assign o_in_stall = busy;
    assign go         = i_in_valid && !busy;

    bfbb_adm u_adm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_front     (front),
        .o_ring_req  (ring_req),
        .o_result    (result)
    );

    bfbb_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ring_req),
        .o_front (front)
    );

    bfbb_oreg u_oreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (go),
        .i_result (result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item),
        .o_busy   (busy)
    );

endmodule
